// ===== rtl/vrt_pkg.sv =====
// Shared types and constants for the voxel ray traversal block.
`default_nettype none
package vrt_pkg;
    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
    localparam logic [19:0] MAX_DIST_RESET = 20'd393216;
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_ANSWER = 1'b1;
    localparam logic [2:0] FACE_PX = 3'd0;

    typedef struct packed {
        logic        func;
        logic [31:0] origin_x;
        logic [31:0] origin_y;
        logic [31:0] origin_z;
        logic [15:0] dir_x;
        logic [15:0] dir_y;
        logic [15:0] dir_z;
        logic        solid;
    } req_t;

    localparam int REQ_W = $bits(req_t);
endpackage
`default_nettype wire

// ===== rtl/vrt_queue.sv =====
// Two-entry request queue between the front end and the traversal engine.
`default_nettype none
module vrt_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire vrt_pkg::req_t        in_data,
    output logic                      out_valid,
    input  wire logic                 out_take,
    output vrt_pkg::req_t             out_data
);
    vrt_pkg::req_t mem_reg [2];
    logic          wptr_reg;
    logic          rptr_reg;
    logic [1:0]    cnt_reg;
    logic          push;
    logic          pop;

    assign in_stall  = (cnt_reg == 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rptr_reg];
    assign push      = in_valid && !in_stall;
    assign pop       = out_valid && out_take;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/vrt_engine.sv =====
// Traversal engine: ray setup (sqrt, divides) and per-answer voxel stepping.
`default_nettype none
module vrt_engine (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_take,
    input  wire vrt_pkg::req_t        req,
    input  wire logic [19:0]          max_distance,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [23:0]               voxel_x,
    output logic [23:0]               voxel_y,
    output logic [23:0]               voxel_z,
    output logic [2:0]                face,
    output logic                      found,
    output logic                      done_res
);
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SQRT  = 7'b0000010,
        ST_DIV   = 7'b0000100,
        ST_MUL   = 7'b0001000,
        ST_PICK  = 7'b0010000,
        ST_STEP  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t       state_reg;
    logic [23:0]  vox_reg   [3];
    logic [31:0]  nc_reg    [3];
    logic [31:0]  cs_reg    [3];
    logic [2:0]   neg_reg;
    logic [15:0]  mag_reg   [3];
    logic [7:0]   frac_reg  [3];
    logic [31:0]  trav_reg;
    logic [2:0]   eface_reg;
    logic         active_reg;
    logic [1:0]   ax_reg;
    logic [1:0]   idx_reg;

    // sqrt working regs: 68 bits wide, v up to 65 bits
    logic [67:0]  sq_v_reg;
    logic [67:0]  sq_r_reg;
    logic [67:0]  sq_bit_reg;
    logic [33:0]  len_reg;

    // divider: len (34b) / mag (16b), restoring, one bit per cycle
    logic [33:0]  dq_reg;
    logic [16:0]  drem_reg;
    logic [5:0]   dcnt_reg;

    logic [23:0]  ovx_reg, ovy_reg, ovz_reg;
    logic [2:0]   oface_reg;
    logic         ofound_reg, odone_reg, ovalid_reg;

    logic [16:0]  dtrial;
    logic [16:0]  dsh;
    logic [67:0]  sq_sum;
    logic [32:0]  nc_sum;
    logic [8:0]   dist_frac;
    logic [40:0]  prod;
    logic [32:0]  len2;
    logic [15:0]  rmag_x, rmag_y, rmag_z;
    logic [31:0]  sqx, sqy, sqz;

    assign rmag_x = req.dir_x[15] ? 16'(-req.dir_x) : req.dir_x;
    assign rmag_y = req.dir_y[15] ? 16'(-req.dir_y) : req.dir_y;
    assign rmag_z = req.dir_z[15] ? 16'(-req.dir_z) : req.dir_z;
    assign sqx    = {16'd0, rmag_x} * {16'd0, rmag_x};
    assign sqy    = {16'd0, rmag_y} * {16'd0, rmag_y};
    assign sqz    = {16'd0, rmag_z} * {16'd0, rmag_z};
    assign len2   = {1'b0, sqx} + {1'b0, sqy} + {1'b0, sqz};
    assign dsh    = {drem_reg[15:0], dq_reg[33]};
    assign dtrial = dsh - {1'b0, mag_reg[idx_reg]};
    assign sq_sum = sq_r_reg + sq_bit_reg;
    assign dist_frac = neg_reg[idx_reg] ? {1'b0, frac_reg[idx_reg]}
                                        : 9'd256 - {1'b0, frac_reg[idx_reg]};
    assign prod   = dist_frac * cs_reg[idx_reg];
    assign nc_sum = {1'b0, nc_reg[ax_reg]} + {1'b0, cs_reg[ax_reg]};

    assign req_take  = (state_reg == ST_IDLE) && req_valid && !ovalid_reg;
    assign out_valid = ovalid_reg;
    assign voxel_x   = ovx_reg;
    assign voxel_y   = ovy_reg;
    assign voxel_z   = ovz_reg;
    assign face      = oface_reg;
    assign found     = ofound_reg;
    assign done_res  = odone_reg;

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_take && req.func == vrt_pkg::FUNC_START)
                begin
                    neg_reg <= {req.dir_z[15], req.dir_y[15], req.dir_x[15]};
                    mag_reg[0] <= rmag_x;
                    mag_reg[1] <= rmag_y;
                    mag_reg[2] <= rmag_z;
                    vox_reg[0] <= req.origin_x[31:8];
                    vox_reg[1] <= req.origin_y[31:8];
                    vox_reg[2] <= req.origin_z[31:8];
                    frac_reg[0] <= req.origin_x[7:0];
                    frac_reg[1] <= req.origin_y[7:0];
                    frac_reg[2] <= req.origin_z[7:0];
                    eface_reg  <= vrt_pkg::FACE_PX;
                    sq_v_reg   <= {3'd0, len2, 32'd0};
                    sq_bit_reg <= {2'b01, 66'd0};
                    sq_r_reg   <= '0;
                end
            end
            ST_SQRT:
            begin
                if (sq_bit_reg != '0)
                begin
                    if (sq_v_reg >= sq_sum)
                    begin
                        sq_v_reg <= sq_v_reg - sq_sum;
                        sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                    end
                    else
                    begin
                        sq_r_reg <= sq_r_reg >> 1;
                    end
                    sq_bit_reg <= sq_bit_reg >> 2;
                end
                else
                begin
                    len_reg  <= sq_r_reg[33:0];
                    dq_reg   <= sq_r_reg[33:0];
                    drem_reg <= '0;
                    dcnt_reg <= '0;
                end
            end
            ST_DIV:
            begin
                if (dcnt_reg != 6'd34)
                begin
                    if (!dtrial[16])
                    begin
                        drem_reg <= dtrial;
                        dq_reg   <= {dq_reg[32:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= dsh;
                        dq_reg   <= {dq_reg[32:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg + 6'd1;
                end
                else
                begin
                    if (mag_reg[idx_reg] == '0 || dq_reg[33:32] != 2'b00)
                    begin
                        cs_reg[idx_reg] <= vrt_pkg::SAT32;
                    end
                    else
                    begin
                        cs_reg[idx_reg] <= dq_reg[31:0];
                    end
                end
            end
            ST_MUL:
            begin
                nc_reg[idx_reg] <= (prod[40] != 1'b0) ? vrt_pkg::SAT32 : prod[39:8];
                dq_reg   <= len_reg;
                drem_reg <= '0;
                dcnt_reg <= '0;
            end
            ST_PICK:
            begin
                if (nc_reg[0] < nc_reg[1] && nc_reg[0] < nc_reg[2])
                begin
                    ax_reg <= 2'd0;
                end
                else if (nc_reg[1] < nc_reg[2])
                begin
                    ax_reg <= 2'd1;
                end
                else
                begin
                    ax_reg <= 2'd2;
                end
            end
            ST_STEP:
            begin
                trav_reg <= nc_reg[ax_reg];
                nc_reg[ax_reg] <= nc_sum[32] ? vrt_pkg::SAT32 : nc_sum[31:0];
                if (neg_reg[ax_reg])
                begin
                    vox_reg[ax_reg] <= vox_reg[ax_reg] - 24'd1;
                    eface_reg <= {ax_reg, 1'b0};
                end
                else
                begin
                    vox_reg[ax_reg] <= vox_reg[ax_reg] + 24'd1;
                    eface_reg <= {ax_reg, 1'b1};
                end
            end
            ST_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            active_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            idx_reg    <= 2'd0;
            ovx_reg <= '0; ovy_reg <= '0; ovz_reg <= '0;
            oface_reg <= '0; ofound_reg <= 1'b0; odone_reg <= 1'b0;
        end
        else
        begin
            if (ovalid_reg && !out_stall)
            begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_take)
                    begin
                        if (req.func == vrt_pkg::FUNC_START)
                        begin
                            active_reg <= 1'b1;
                            idx_reg    <= 2'd0;
                            state_reg  <= ST_SQRT;
                        end
                        else if (!active_reg)
                        begin
                            ovalid_reg <= 1'b1;
                            ovx_reg <= '0; ovy_reg <= '0; ovz_reg <= '0;
                            oface_reg <= vrt_pkg::FACE_PX;
                            ofound_reg <= 1'b0; odone_reg <= 1'b1;
                        end
                        else if (req.solid)
                        begin
                            active_reg <= 1'b0;
                            ovalid_reg <= 1'b1;
                            ovx_reg <= vox_reg[0]; ovy_reg <= vox_reg[1];
                            ovz_reg <= vox_reg[2];
                            oface_reg <= eface_reg;
                            ofound_reg <= 1'b1; odone_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= ST_PICK;
                        end
                    end
                end
                ST_SQRT:
                begin
                    if (sq_bit_reg == '0)
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (dcnt_reg == 6'd34)
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    if (idx_reg == 2'd2)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= ST_DIV;
                    end
                end
                ST_PICK:
                begin
                    state_reg <= ST_STEP;
                end
                ST_STEP:
                begin
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!ovalid_reg)
                    begin
                        ovalid_reg <= 1'b1;
                        state_reg  <= ST_IDLE;
                        oface_reg  <= vrt_pkg::FACE_PX;
                        ofound_reg <= 1'b0;
                        if ((idx_reg == 2'd2 && max_distance == '0)
                            || (idx_reg != 2'd2 && trav_reg >= {12'd0, max_distance}))
                        begin
                            active_reg <= 1'b0;
                            ovx_reg <= '0; ovy_reg <= '0; ovz_reg <= '0;
                            odone_reg <= 1'b1;
                        end
                        else
                        begin
                            ovx_reg <= vox_reg[0]; ovy_reg <= vox_reg[1];
                            ovz_reg <= vox_reg[2];
                            odone_reg <= 1'b0;
                        end
                        idx_reg <= 2'd0;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/voxel_ray_traversal.sv =====
// Top level: APB register, request queue and traversal engine.
// Answer requests: when a step is taken, the request passes from the queue through
// the pick, step and output states; a solid answer or one with no ray is answered from idle.
// Start requests: set up by the bit-serial square root and then three 34-step restoring
// divides sharing one divider, each followed by the multiply.
// One request is worked at a time and none is taken while a result waits; the
// two-entry queue takes requests meanwhile. Reset (rst_n, async low) clears
// control state and sets max_distance to 6.0.
`default_nettype none
module voxel_ray_traversal (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [1:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire logic         func,
    input  wire logic [31:0]  origin_x,
    input  wire logic [31:0]  origin_y,
    input  wire logic [31:0]  origin_z,
    input  wire logic [15:0]  dir_x,
    input  wire logic [15:0]  dir_y,
    input  wire logic [15:0]  dir_z,
    input  wire logic         solid,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic [23:0]       voxel_x,
    output logic [23:0]       voxel_y,
    output logic [23:0]       voxel_z,
    output logic [2:0]        face,
    output logic              found,
    output logic              done_res
);
    logic [19:0]    maxd_reg;
    vrt_pkg::req_t  in_req;
    vrt_pkg::req_t  q_req;
    logic           q_valid;
    logic           q_take;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {12'd0, maxd_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maxd_reg <= vrt_pkg::MAX_DIST_RESET;
        end
        else if (psel && penable && pwrite && paddr == 2'd0)
        begin
            maxd_reg <= pwdata[19:0];
        end
    end

    assign in_req = '{func: func, origin_x: origin_x, origin_y: origin_y,
                      origin_z: origin_z, dir_x: dir_x, dir_y: dir_y,
                      dir_z: dir_z, solid: solid};

    vrt_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_req),
        .out_valid(q_valid), .out_take(q_take), .out_data(q_req)
    );

    vrt_engine u_engine (
        .clk(clk), .rst_n(rst_n),
        .req_valid(q_valid), .req_take(q_take), .req(q_req),
        .max_distance(maxd_reg),
        .out_valid(out_valid), .out_stall(out_stall),
        .voxel_x(voxel_x), .voxel_y(voxel_y), .voxel_z(voxel_z),
        .face(face), .found(found), .done_res(done_res)
    );
endmodule
`default_nettype wire
